[hdl/vn_pkg.sv]
// ----------------------------------------------------------------------------
// vn_pkg
// shared types and constants of the vector normaliser pipeline
// ----------------------------------------------------------------------------
package vn_pkg;

    localparam int unsigned LANES    = 4;
    localparam int unsigned SQ_STEPS = 32;
    localparam int unsigned DV_STEPS = 31;

    localparam logic [2:0] DIM_MIN   = 3'd2;
    localparam logic [2:0] DIM_MAX   = 3'd4;
    localparam logic [2:0] DIM_RESET = 3'd3;

    typedef struct packed {
        logic signed [31:0] component_3;
        logic signed [31:0] component_2;
        logic signed [31:0] component_1;
        logic signed [31:0] component_0;
    } t_in_item;

    typedef struct packed {
        logic               zero_vector;
        logic        [32:0] length;
        logic signed [31:0] unit_3;
        logic signed [31:0] unit_2;
        logic signed [31:0] unit_1;
        logic signed [31:0] unit_0;
    } t_out_item;

    // state handed along the square root chain
    typedef struct packed {
        logic                    valid;
        logic                    big;
        logic [63:0]             x;
        logic [33:0]             rem;
        logic [31:0]             root;
        logic [LANES-1:0][31:0]  mag;
        logic [LANES-1:0]        neg;
    } t_sq;

    // state handed along the divider chain
    typedef struct packed {
        logic                    valid;
        logic [32:0]             len;
        logic [LANES-1:0]        neg;
        logic [LANES-1:0][32:0]  rem;
        logic [LANES-1:0][30:0]  q;
        logic [LANES-1:0][30:0]  d;
    } t_dv;

endpackage

[hdl/vn_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// vn_sqrt_cell
// one restoring square root step, one result bit per cell
// ----------------------------------------------------------------------------
module vn_sqrt_cell (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  vn_pkg::t_sq i_sq,
    output vn_pkg::t_sq o_sq
);
    import vn_pkg::*;

    t_sq        r_sq;
    t_sq        n_sq;
    logic [35:0] t;
    logic [35:0] trial;

    always_comb begin
        n_sq  = i_sq;
        t     = {i_sq.rem, i_sq.x[63:62]};
        trial = {2'b00, i_sq.root, 2'b01};
        n_sq.x = {i_sq.x[61:0], 2'b00};
        if (t >= trial) begin
            n_sq.rem  = 34'(t - trial);
            n_sq.root = {i_sq.root[30:0], 1'b1};
        end else begin
            n_sq.rem  = t[33:0];
            n_sq.root = {i_sq.root[30:0], 1'b0};
        end
    end

    // only the valid bit is reset, the payload simply follows the enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq.valid <= 1'b0;
        end else if (i_en) begin
            r_sq.valid <= n_sq.valid;
        end
        if (i_en) begin
            r_sq.big  <= n_sq.big;
            r_sq.x    <= n_sq.x;
            r_sq.rem  <= n_sq.rem;
            r_sq.root <= n_sq.root;
            r_sq.mag  <= n_sq.mag;
            r_sq.neg  <= n_sq.neg;
        end
    end

    assign o_sq = r_sq;

endmodule

[hdl/vn_div_cell.sv]
// ----------------------------------------------------------------------------
// vn_div_cell
// one restoring division step for all four lanes, one quotient bit per cell
// ----------------------------------------------------------------------------
module vn_div_cell (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  vn_pkg::t_dv i_dv,
    output vn_pkg::t_dv o_dv
);
    import vn_pkg::*;

    t_dv                    r_dv;
    t_dv                    n_dv;
    logic [LANES-1:0][33:0] t;

    always_comb begin
        n_dv = i_dv;
        for (int g = 0; g < LANES; g++) begin
            t[g]        = {i_dv.rem[g], i_dv.d[g][30]};
            n_dv.d[g]   = {i_dv.d[g][29:0], 1'b0};
            if (t[g] >= {1'b0, i_dv.len}) begin
                n_dv.rem[g] = 33'(t[g] - {1'b0, i_dv.len});
                n_dv.q[g]   = {i_dv.q[g][29:0], 1'b1};
            end else begin
                n_dv.rem[g] = t[g][32:0];
                n_dv.q[g]   = {i_dv.q[g][29:0], 1'b0};
            end
        end
    end

    // only the valid bit is reset, the payload simply follows the enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv.valid <= 1'b0;
        end else if (i_en) begin
            r_dv.valid <= n_dv.valid;
        end
        if (i_en) begin
            r_dv.len <= n_dv.len;
            r_dv.neg <= n_dv.neg;
            r_dv.rem <= n_dv.rem;
            r_dv.q   <= n_dv.q;
            r_dv.d   <= n_dv.d;
        end
    end

    assign o_dv = r_dv;

endmodule

[hdl/vector_normalize.sv]
// ----------------------------------------------------------------------------
// vector_normalize
// fixed-point vector normaliser: magnitude by square root, unit vector by divide
// ----------------------------------------------------------------------------
// pipeline: 4 front stages, 32 square root cells, 31 divider cells and
//   1 output register between input transaction and result
// throughput: one vector per cycle; the whole pipe advances together and
//   holds only while a waiting result is stalled
// reset: synchronous active low, empties the pipe and sets dimensions to 3
module vector_normalize (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  vn_pkg::t_in_item  i_in_data,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output vn_pkg::t_out_item o_out_data,
    // dimensions register write
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_data
);
    import vn_pkg::*;

    // pipe enable: everything moves unless the held result is stalled
    logic en;
    assign en          = ~o_out_valid | ~i_out_stall;
    assign o_in_stall  = ~en;
    assign o_cfg_ready = 1'b1;

    // dimensions register
    logic [2:0] r_dims;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= DIM_RESET;
        end else if (i_cfg_valid) begin
            r_dims <= i_cfg_data;
        end
    end

    // clamp dimensions into two to four and derive lane use
    logic [2:0]       dims_eff;
    logic [LANES-1:0] lane_use;
    always_comb begin
        priority if (r_dims < DIM_MIN) begin
            dims_eff = DIM_MIN;
        end else if (r_dims > DIM_MAX) begin
            dims_eff = DIM_MAX;
        end else begin
            dims_eff = r_dims;
        end
        lane_use = {dims_eff >= 3'd4, dims_eff >= 3'd3, 2'b11};
    end

    // stage 0: magnitudes and signs, unused lanes forced to zero
    logic [LANES-1:0][31:0] comp;
    logic [LANES-1:0][31:0] n_s0_mag;
    logic [LANES-1:0]       n_s0_neg;
    assign comp = {i_in_data.component_3, i_in_data.component_2,
                   i_in_data.component_1, i_in_data.component_0};

    always_comb begin
        for (int g = 0; g < LANES; g++) begin
            n_s0_neg[g] = lane_use[g] & comp[g][31];
            if (!lane_use[g]) begin
                n_s0_mag[g] = '0;
            end else if (comp[g][31]) begin
                n_s0_mag[g] = 32'(-comp[g]);
            end else begin
                n_s0_mag[g] = comp[g];
            end
        end
    end

    logic                   r_s0_valid;
    logic [LANES-1:0][31:0] r_s0_mag;
    logic [LANES-1:0]       r_s0_neg;
    // stage 1: squares
    logic                   r_s1_valid;
    logic [LANES-1:0][63:0] r_s1_sq;
    logic [LANES-1:0][31:0] r_s1_mag;
    logic [LANES-1:0]       r_s1_neg;
    // stage 2: pair sums
    logic                   r_s2_valid;
    logic [64:0]            r_s2_a;
    logic [64:0]            r_s2_b;
    logic [LANES-1:0][31:0] r_s2_mag;
    logic [LANES-1:0]       r_s2_neg;
    // stage 3: full sum of squares
    logic                   r_s3_valid;
    logic [64:0]            r_s3_sum;
    logic [LANES-1:0][31:0] r_s3_mag;
    logic [LANES-1:0]       r_s3_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= i_in_valid;
            r_s1_valid <= r_s0_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_mag <= n_s0_mag;
            r_s0_neg <= n_s0_neg;
            for (int g = 0; g < LANES; g++) begin
                r_s1_sq[g] <= r_s0_mag[g] * r_s0_mag[g];
            end
            r_s1_mag <= r_s0_mag;
            r_s1_neg <= r_s0_neg;
            r_s2_a   <= {1'b0, r_s1_sq[0]} + {1'b0, r_s1_sq[1]};
            r_s2_b   <= {1'b0, r_s1_sq[2]} + {1'b0, r_s1_sq[3]};
            r_s2_mag <= r_s1_mag;
            r_s2_neg <= r_s1_neg;
            // sum never exceeds 2^64, so 65 bits hold it exactly
            r_s3_sum <= r_s2_a + r_s2_b;
            r_s3_mag <= r_s2_mag;
            r_s3_neg <= r_s2_neg;
        end
    end

    // square root chain: one root bit per cell, msb first
    t_sq sq_head;
    t_sq sq_link [SQ_STEPS+1];

    always_comb begin
        sq_head.valid = r_s3_valid;
        // the only sum with bit 64 set is exactly 2^64, root 2^32
        sq_head.big   = r_s3_sum[64];
        sq_head.x     = r_s3_sum[63:0];
        sq_head.rem   = '0;
        sq_head.root  = '0;
        sq_head.mag   = r_s3_mag;
        sq_head.neg   = r_s3_neg;
    end

    assign sq_link[0] = sq_head;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        vn_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_sq    (sq_link[k]),
            .o_sq    (sq_link[k+1])
        );
    end

    // divider chain: quotient of mag * 2^30 by length, 31 bits per lane
    // mag <= length, so mag >> 1 already lies below length and seeds the remainder
    t_dv dv_head;
    t_dv dv_link [DV_STEPS+1];

    always_comb begin
        dv_head.valid = sq_link[SQ_STEPS].valid;
        dv_head.len   = sq_link[SQ_STEPS].big ? {1'b1, 32'd0}
                                              : {1'b0, sq_link[SQ_STEPS].root};
        dv_head.neg   = sq_link[SQ_STEPS].neg;
        for (int g = 0; g < LANES; g++) begin
            dv_head.rem[g] = {2'b00, sq_link[SQ_STEPS].mag[g][31:1]};
            dv_head.q[g]   = '0;
            dv_head.d[g]   = {sq_link[SQ_STEPS].mag[g][0], 30'd0};
        end
    end

    assign dv_link[0] = dv_head;

    for (genvar k = 0; k < DV_STEPS; k++) begin : g_div
        vn_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_dv    (dv_link[k]),
            .o_dv    (dv_link[k+1])
        );
    end

    // sign restore and zero magnitude handling
    t_dv                    dv_end;
    logic                   len_zero;
    logic [LANES-1:0][31:0] unit;
    assign dv_end   = dv_link[DV_STEPS];
    assign len_zero = (dv_end.len == '0);

    always_comb begin
        for (int g = 0; g < LANES; g++) begin
            if (len_zero) begin
                unit[g] = '0;
            end else if (dv_end.neg[g]) begin
                unit[g] = 32'(-{1'b0, dv_end.q[g]});
            end else begin
                unit[g] = {1'b0, dv_end.q[g]};
            end
        end
    end

    // output register
    logic      r_out_valid;
    t_out_item r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_end.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data.unit_0      <= unit[0];
            r_out_data.unit_1      <= unit[1];
            r_out_data.unit_2      <= unit[2];
            r_out_data.unit_3      <= unit[3];
            r_out_data.length      <= dv_end.len;
            r_out_data.zero_vector <= len_zero;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[tb/sv/tb_vector_normalize.sv]
// ----------------------------------------------------------------------------
// tb_vector_normalize
// self-checking bench for the vector normaliser: directed and random vectors
// under every dimensions setting, with random idling on both channels
// ----------------------------------------------------------------------------
module tb_vector_normalize;
    timeunit 1ns;
    timeprecision 1ps;

    import vn_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int PHASE_ITEMS    = 230;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_data;

    // one directed row: the dimensions it runs under, the vector, and an
    // optional hand-written result
    typedef struct {
        logic [2:0] dims;
        t_in_item   vec;
        bit         typed;
        t_out_item  res;
    } t_row;

    t_out_item  unit_q[$];     // expected unit vectors, oldest first
    logic [2:0] cur_dims;      // bench copy of the dimensions register
    int         fail_count;
    bit         quiet;         // no idling in the closing phase
    int         idle_cycles;
    t_row       rows[16];

    vector_normalize u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // floor square root of the exact 65-bit sum of squares
    function automatic logic [32:0] floor_root(logic [64:0] v);
        logic [65:0] rem;
        logic [65:0] res;
        logic [65:0] b;
        rem = {1'b0, v};
        res = '0;
        b   = 66'd1 << 64;
        while (b > rem) b >>= 2;
        while (b != 0) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res[32:0];
    endfunction

    // predicted unit vector, length and zero flag for one vector
    function automatic t_out_item normalise(t_in_item vec, logic [2:0] dims);
        logic [31:0] lane [4];
        logic [32:0] mag [4];
        bit          neg [4];
        logic [64:0] sum;
        logic [32:0] len;
        logic [62:0] q;
        logic [31:0] u [4];
        int          n;
        t_out_item   r;
        lane[0] = vec.component_0;
        lane[1] = vec.component_1;
        lane[2] = vec.component_2;
        lane[3] = vec.component_3;
        // register values outside two to four are clamped
        n   = (dims < 2) ? 2 : (dims > 4) ? 4 : int'(dims);
        sum = '0;
        for (int i = 0; i < 4; i++) begin
            neg[i] = (i < n) && lane[i][31];
            if (i >= n)
                mag[i] = '0;
            else if (neg[i])
                mag[i] = 33'h1_0000_0000 - {1'b0, lane[i]};
            else
                mag[i] = {1'b0, lane[i]};
            sum += 65'(mag[i]) * 65'(mag[i]);
        end
        len = floor_root(sum);
        for (int i = 0; i < 4; i++) begin
            u[i] = '0;
            if (len != 0 && i < n) begin
                q    = {mag[i][31:0], 30'b0} / 63'(len);
                u[i] = neg[i] ? -q[31:0] : q[31:0];
            end
        end
        r.unit_0      = u[0];
        r.unit_1      = u[1];
        r.unit_2      = u[2];
        r.unit_3      = u[3];
        r.length      = len;
        r.zero_vector = (len == 0);
        return r;
    endfunction

    // drive one vector and hold it until the block takes it
    task automatic send_vector(t_in_item vec, bit typed, t_out_item res);
        int gap;
        i_in_valid = 1'b1;
        i_in_data  = vec;
        do @(posedge i_clk); while (o_in_stall);
        unit_q.push_back(typed ? res : normalise(vec, cur_dims));
        @(negedge i_clk);
        // occasional gap burst before the next transaction
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap        = $urandom_range(1, 19);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // wait for the pipe to empty, then write the dimensions register
    task automatic set_dims(logic [2:0] d);
        i_in_valid = 1'b0;
        while (unit_q.size() != 0) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = d;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_dims = d;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] rand_lane();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0;
            3:       return 32'($signed($urandom_range(0, 511)) - 256);
            4:       return 32'($signed($urandom_range(0, 2**20)) - 2**19);
            default: return $urandom;
        endcase
    endfunction

    // result check against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (unit_q.size() == 0) begin
                $error("result transaction with nothing expected");
                fail_count++;
            end else begin
                want = unit_q.pop_front();
                if (o_out_data.unit_0 !== want.unit_0) begin
                    $error("unit_0 expected %h actual %h", want.unit_0, o_out_data.unit_0);
                    fail_count++;
                end
                if (o_out_data.unit_1 !== want.unit_1) begin
                    $error("unit_1 expected %h actual %h", want.unit_1, o_out_data.unit_1);
                    fail_count++;
                end
                if (o_out_data.unit_2 !== want.unit_2) begin
                    $error("unit_2 expected %h actual %h", want.unit_2, o_out_data.unit_2);
                    fail_count++;
                end
                if (o_out_data.unit_3 !== want.unit_3) begin
                    $error("unit_3 expected %h actual %h", want.unit_3, o_out_data.unit_3);
                    fail_count++;
                end
                if (o_out_data.length !== want.length) begin
                    $error("length expected %h actual %h", want.length, o_out_data.length);
                    fail_count++;
                end
                if (o_out_data.zero_vector !== want.zero_vector) begin
                    $error("zero_vector expected %b actual %b",
                           want.zero_vector, o_out_data.zero_vector);
                    fail_count++;
                end
            end
        end
    end

    // result side stall bursts
    always @(negedge i_clk) begin
        if (idle_cycles > 0) begin
            idle_cycles--;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            idle_cycles = $urandom_range(1, 19);
        end
        i_out_stall <= (idle_cycles > 0);
    end

    // watchdog on cycles with no transaction anywhere
    always @(posedge i_clk) begin
        int still;
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            still = 0;
        else
            still++;
        if (still >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        t_out_item none;
        t_in_item  vec;
        logic [2:0] dims_seq [8] = '{3'd0, 3'd7, 3'd2, 3'd5, 3'd1, 3'd4, 3'd6, 3'd3};
        none        = '0;
        fail_count  = 0;
        quiet       = 1'b0;
        idle_cycles = 0;
        cur_dims    = DIM_RESET;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;

        // directed rows, grouped by dimensions; reset value first
        rows[0]  = '{3'd3, '{32'h1234_5678, 32'h0, 32'h0, 32'h0}, 1,
                     '{1'b1, 33'h0, 32'h0, 32'h0, 32'h0, 32'h0}};        // zero vector, stray lane 3
        rows[1]  = '{3'd3, '{32'h0, 32'h0, 32'h0, 32'h0001_0000}, 0, none};
        rows[2]  = '{3'd3, '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}, 0, none};
        rows[3]  = '{3'd3, '{32'h0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001}, 0, none};
        rows[4]  = '{3'd3, '{32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF}, 0, none};
        rows[5]  = '{3'd2, '{32'h0, 32'h0, 32'h0, 32'h0001_0000}, 1,
                     '{1'b0, 33'h1_0000, 32'h0, 32'h0, 32'h0, 32'h4000_0000}}; // unit x axis
        rows[6]  = '{3'd2, '{32'h0, 32'h0, 32'h0, 32'hFFFF_0000}, 1,
                     '{1'b0, 33'h1_0000, 32'h0, 32'h0, 32'h0, 32'hC000_0000}}; // minus one
        rows[7]  = '{3'd2, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
                     0, none};
        rows[8]  = '{3'd2, '{32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000}, 0, none};
        rows[9]  = '{3'd2, '{32'h1, 32'h1, 32'h0, 32'h1}, 0, none};
        rows[10] = '{3'd4, '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1,
                     '{1'b0, 33'h1_0000_0000, 32'hE000_0000, 32'hE000_0000,
                       32'hE000_0000, 32'hE000_0000}};                    // largest length
        rows[11] = '{3'd4, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
                     0, none};
        rows[12] = '{3'd4, '{32'h0000_0003, 32'h0, 32'h0, 32'h0}, 0, none};
        rows[13] = '{3'd4, '{32'h0, 32'h0, 32'h0, 32'h0}, 1,
                     '{1'b1, 33'h0, 32'h0, 32'h0, 32'h0, 32'h0}};
        rows[14] = '{3'd4, '{32'hFFFF_FFFF, 32'h0000_0002, 32'hFFFF_FFFD, 32'h0000_0004},
                     0, none};
        rows[15] = '{3'd4, '{32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210},
                     0, none};

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[k]) begin
            if (rows[k].dims != cur_dims)
                set_dims(rows[k].dims);
            send_vector(rows[k].vec, rows[k].typed, rows[k].res);
        end

        // random phases across every register value, the last one without idling
        foreach (dims_seq[p]) begin
            set_dims(dims_seq[p]);
            if (p == 7)
                quiet = 1'b1;
            for (int j = 0; j < PHASE_ITEMS; j++) begin
                vec.component_0 = rand_lane();
                vec.component_1 = rand_lane();
                vec.component_2 = rand_lane();
                vec.component_3 = rand_lane();
                // now and then a zero vector in the used lanes only
                if ($urandom_range(0, 19) == 0) begin
                    vec.component_0 = '0;
                    vec.component_1 = '0;
                    if (dims_seq[p] >= 3) vec.component_2 = '0;
                    if (dims_seq[p] >= 4 && dims_seq[p] != 3) vec.component_3 = '0;
                end
                send_vector(vec, 1'b0, none);
            end
        end

        i_in_valid = 1'b0;
        while (unit_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
